// ----- design/ipfe_pkg.sv -----
// Package for the IR pulse frame encoder.
// Holds protocol codes, pulse timings, descriptor and phase types.
// No dependencies; every module of the block imports it.
`default_nettype none

package ipfe_pkg;

  // Largest frame the encoder will send, in bits.
  localparam int unsigned MAX_FRAME_BITS = 32;

  // Protocol codes carried on the opcode port.
  localparam logic [2:0] OP_NEC     = 3'd0;
  localparam logic [2:0] OP_NECEXT  = 3'd1;
  localparam logic [2:0] OP_SAMSUNG = 3'd2;
  localparam logic [2:0] OP_SIRC12  = 3'd3;
  localparam logic [2:0] OP_SIRC15  = 3'd4;
  localparam logic [2:0] OP_SIRC20  = 3'd5;
  localparam logic [2:0] OP_SONY    = 3'd6;
  localparam logic [2:0] OP_UNSUP   = 3'd7;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_COUNT = 2'd1;
  localparam logic [1:0] STATUS_BAD_PROTO = 2'd2;

  // Pulse timings in microseconds.
  localparam logic [15:0] T_NEC_LEAD_MARK = 16'd9000;
  localparam logic [15:0] T_NEC_LEAD_SPACE = 16'd4500;
  localparam logic [15:0] T_NEC_BIT_MARK  = 16'd560;
  localparam logic [15:0] T_NEC_ONE_SPACE = 16'd1690;
  localparam logic [15:0] T_NEC_STOP_SPACE = 16'd1;
  localparam logic [15:0] T_SIRC_LEAD_MARK = 16'd2400;
  localparam logic [15:0] T_SIRC_ONE_MARK = 16'd1200;
  localparam logic [15:0] T_SIRC_UNIT     = 16'd600;
  localparam logic [15:0] T_SIRC_ONE_BIT  = 16'd1800;
  localparam logic [15:0] T_SIRC_LEAD_TOTAL = 16'd3000;
  localparam logic [15:0] T_SIRC_FRAME    = 16'd45000;

  // SIRC field masks.
  localparam logic [15:0] SIRC_ADDR_MASK = 16'h1fff;
  localparam logic [7:0]  SIRC_CMD_MASK  = 8'h7f;

  // Fixed SIRC frame lengths.
  localparam logic [5:0] SIRC12_BITS = 6'd12;
  localparam logic [5:0] SIRC15_BITS = 6'd15;
  localparam logic [5:0] SIRC20_BITS = 6'd20;

  // How the back end has to send a frame.
  typedef enum logic [1:0] {
    KIND_PULSE_DIST,
    KIND_PULSE_WIDTH,
    KIND_ERROR
  } kind_t;

  // One classified frame, passed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  status;
    logic        samsung;
    logic [31:0] word;
    logic [5:0]  bits;
  } desc_t;

  // Sequencer phase of the back end.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEADER,
    PH_BITS,
    PH_STOP
  } phase_t;

endpackage

`default_nettype wire

// ----- design/ipfe_front.sv -----
// Front end of the IR pulse frame encoder: classifies a request and builds
// the frame word and bit count. Depends on ipfe_pkg.
`default_nettype none

module ipfe_front
  import ipfe_pkg::*;
(
  input  wire logic [2:0]  opcode,
  input  wire logic        from_address_command,
  input  wire logic [31:0] data_word,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  command,
  input  wire logic [5:0]  bit_count,
  output desc_t            desc
);

  logic [7:0]  addr_lo;
  logic [31:0] word;
  logic [31:0] sirc_word;
  logic [5:0]  bits;
  logic [5:0]  align;
  kind_t       kind;
  logic [1:0]  status;

  assign addr_lo = address[7:0];
  assign sirc_word = {12'd0, address[12:0] & SIRC_ADDR_MASK[12:0],
                      command[6:0] & SIRC_CMD_MASK[6:0]};

  // Build the frame word and its length per protocol.
  always_comb begin
    word   = data_word;
    bits   = bit_count;
    kind   = KIND_PULSE_DIST;
    status = STATUS_OK;
    unique case (opcode) inside
      OP_NEC, OP_NECEXT, OP_SAMSUNG: begin
        if (from_address_command) begin
          bits = 6'd32;
          unique case (opcode)
            OP_NEC:    word[31:16] = {addr_lo, ~addr_lo};
            OP_NECEXT: word[31:16] = address;
            default:   word[31:16] = {addr_lo, addr_lo};
          endcase
          word[15:0] = {command, ~command};
        end
      end
      OP_SIRC12, OP_SIRC15, OP_SIRC20, OP_SONY: begin
        kind = KIND_PULSE_WIDTH;
        if (from_address_command) begin
          word = sirc_word;
        end
        unique case (opcode)
          OP_SIRC12: bits = SIRC12_BITS;
          OP_SIRC15: bits = SIRC15_BITS;
          OP_SIRC20: bits = SIRC20_BITS;
          default:   bits = from_address_command ? SIRC12_BITS : bit_count;
        endcase
      end
      default: begin
        kind   = KIND_ERROR;
        status = STATUS_BAD_PROTO;
      end
    endcase
    // A frame must hold at least one bit and fit the frame register.
    if (kind != KIND_ERROR && (bits == 6'd0 || bits > 6'(MAX_FRAME_BITS))) begin
      kind   = KIND_ERROR;
      status = STATUS_BAD_COUNT;
    end
  end

  // MSB-first frames are left-aligned so the back end always sends bit 31.
  assign align = 6'd32 - bits;

  always_comb begin
    desc.kind    = kind;
    desc.status  = status;
    desc.samsung = (opcode == OP_SAMSUNG);
    desc.bits    = bits;
    desc.word    = (kind == KIND_PULSE_DIST) ? (word << align[4:0]) : word;
  end

endmodule

`default_nettype wire

// ----- design/ipfe_queue.sv -----
// Two-entry queue of frame descriptors between the front and back ends.
// Depends on ipfe_pkg for the descriptor type.
`default_nettype none

module ipfe_queue
  import ipfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output desc_t      pop_desc
);

  desc_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_desc  = mem[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/ipfe_back.sv -----
// Back end of the IR pulse frame encoder: steps through one frame and
// emits one mark/space pair per cycle into an output register while that
// register is free or being read. Depends on ipfe_pkg.
`default_nettype none

module ipfe_back
  import ipfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire desc_t q_desc,
  output logic      q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [15:0] mark_us,
  output logic [15:0] space_us,
  output logic [1:0]  status,
  output logic        last
);

  phase_t      phase, phase_next;
  kind_t       kind, kind_next;
  logic [1:0]  err, err_next;
  logic        samsung, samsung_next;
  logic [31:0] word, word_next;
  logic [5:0]  remaining, remaining_next;
  logic [15:0] dur, dur_next;

  logic        slot_free;
  logic        emit;
  logic [15:0] e_mark;
  logic [15:0] e_space;
  logic [1:0]  e_status;
  logic        e_last;
  logic        one;
  logic        final_bit;
  logic [15:0] dur_sum;

  assign slot_free = !out_valid || out_ready;
  assign one       = (kind == KIND_PULSE_WIDTH) ? word[0] : word[31];
  assign final_bit = (remaining == 6'd1);
  assign dur_sum   = dur + (one ? T_SIRC_ONE_BIT : T_SIRC_ONE_MARK);

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    kind      <= kind_next;
    err       <= err_next;
    samsung   <= samsung_next;
    word      <= word_next;
    remaining <= remaining_next;
    dur       <= dur_next;
  end

  // Next phase and the pair to emit.
  always_comb begin
    phase_next     = phase;
    kind_next      = kind;
    err_next       = err;
    samsung_next   = samsung;
    word_next      = word;
    remaining_next = remaining;
    dur_next       = dur;
    q_pop          = 1'b0;
    emit           = 1'b0;
    e_mark         = 16'd0;
    e_space        = 16'd0;
    e_status       = STATUS_OK;
    e_last         = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          kind_next      = q_desc.kind;
          err_next       = q_desc.status;
          samsung_next   = q_desc.samsung;
          word_next      = q_desc.word;
          remaining_next = q_desc.bits;
          dur_next       = T_SIRC_LEAD_TOTAL;
          phase_next     = PH_LEADER;
        end
      end
      PH_LEADER: begin
        if (slot_free) begin
          emit = 1'b1;
          unique case (kind)
            KIND_PULSE_DIST: begin
              e_mark     = samsung ? T_NEC_LEAD_SPACE : T_NEC_LEAD_MARK;
              e_space    = T_NEC_LEAD_SPACE;
              phase_next = PH_BITS;
            end
            KIND_PULSE_WIDTH: begin
              e_mark     = T_SIRC_LEAD_MARK;
              e_space    = T_SIRC_UNIT;
              phase_next = PH_BITS;
            end
            default: begin
              e_status   = err;
              e_last     = 1'b1;
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
      PH_BITS: begin
        if (slot_free) begin
          emit           = 1'b1;
          remaining_next = remaining - 6'd1;
          if (kind == KIND_PULSE_WIDTH) begin
            // Pulse width, LSB first; the last space pads out the frame.
            e_mark    = one ? T_SIRC_ONE_MARK : T_SIRC_UNIT;
            word_next = word >> 1;
            dur_next  = dur_sum;
            if (final_bit) begin
              e_last     = 1'b1;
              phase_next = PH_IDLE;
              if (dur_sum < T_SIRC_FRAME) begin
                e_space = T_SIRC_FRAME + T_SIRC_UNIT - dur_sum;
              end else begin
                e_space = T_SIRC_UNIT + T_SIRC_UNIT;
              end
            end else begin
              e_space = T_SIRC_UNIT;
            end
          end else begin
            // Pulse distance, MSB first.
            e_mark    = T_NEC_BIT_MARK;
            e_space   = one ? T_NEC_ONE_SPACE : T_NEC_BIT_MARK;
            word_next = word << 1;
            if (final_bit) begin
              phase_next = PH_STOP;
            end
          end
        end
      end
      default: begin
        // Stop pair closes a pulse-distance frame.
        if (slot_free) begin
          emit       = 1'b1;
          e_mark     = T_NEC_BIT_MARK;
          e_space    = T_NEC_STOP_SPACE;
          e_last     = 1'b1;
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mark_us  <= e_mark;
      space_us <= e_space;
      status   <= e_status;
      last     <= e_last;
    end
  end

endmodule

`default_nettype wire

// ----- design/ir_pulse_frame_encoder.sv -----
// IR pulse frame encoder: one request in, a frame of mark/space pairs out.
// The first pair of a taken item goes through the queue, the idle phase of the
// sequencer and the output register. The sequencer sends one pair per cycle
// while the output is not stalled; it idles between frames to take the next item.
// A two-entry queue lets up to two further items be taken during a frame.
// Reset (rst, synchronous) empties the queue, idles the sequencer, drops out_valid.
`default_nettype none

module ir_pulse_frame_encoder
  import ipfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic        from_address_command,
  input  wire logic [31:0] data_word,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  command,
  input  wire logic [5:0]  bit_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      mark_us,
  output logic [15:0]      space_us,
  output logic [1:0]       status,
  output logic             last
);

  desc_t front_desc;
  desc_t q_desc;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  assign in_ready = !q_full;

  // Classify the request.
  ipfe_front u_front (
    .opcode               (opcode),
    .from_address_command (from_address_command),
    .data_word            (data_word),
    .address              (address),
    .command              (command),
    .bit_count            (bit_count),
    .desc                 (front_desc)
  );

  // Hold classified items until the sequencer is free.
  ipfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_desc (front_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_desc  (q_desc)
  );

  // Emit the pairs.
  ipfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mark_us   (mark_us),
    .space_us  (space_us),
    .status    (status),
    .last      (last)
  );

endmodule

`default_nettype wire

// ----- design/ipfe_checker.sv -----
// Port-level checks for the IR pulse frame encoder, bound to the top level.
// Depends on ipfe_pkg for status codes and timings.
`default_nettype none

module ipfe_checker
  import ipfe_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  opcode,
  input wire logic        from_address_command,
  input wire logic [31:0] data_word,
  input wire logic [15:0] address,
  input wire logic [7:0]  command,
  input wire logic [5:0]  bit_count,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] mark_us,
  input wire logic [15:0] space_us,
  input wire logic [1:0]  status,
  input wire logic        last
);

  // A waiting request item keeps its valid and its fields.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(opcode)
      && $stable(from_address_command) && $stable(data_word) && $stable(address)
      && $stable(command) && $stable(bit_count))
    else $error("request item changed while waiting");

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mark_us) && $stable(space_us)
      && $stable(status) && $stable(last))
    else $error("result item changed while stalled");

  // An error result is a single, final, empty pair.
  a_err_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> last && mark_us == 16'd0 && space_us == 16'd0)
    else $error("error result is not a single empty pair");

  // Only the three status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_OK || status == STATUS_BAD_COUNT
      || status == STATUS_BAD_PROTO)
    else $error("unknown status code");

  // A good pair carries one of the protocol mark widths.
  a_mark_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> mark_us == T_NEC_LEAD_MARK
      || mark_us == T_NEC_LEAD_SPACE || mark_us == T_NEC_BIT_MARK
      || mark_us == T_SIRC_LEAD_MARK || mark_us == T_SIRC_ONE_MARK
      || mark_us == T_SIRC_UNIT)
    else $error("mark width outside the protocol set");

endmodule

bind ir_pulse_frame_encoder ipfe_checker u_ipfe_checker (.*);

`default_nettype wire

// ----- verif/ir_pulse_frame_encoder_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the IR pulse frame encoder: directed and random
// frame requests, with each mark/space pair checked against a local prediction.
// Depends on ipfe_pkg and the encoder RTL under design/.

import ipfe_pkg::*;

// One frame request as it crosses the input handshake.
typedef struct packed {
  logic [2:0]  opcode;
  logic        from_address_command;
  logic [31:0] data_word;
  logic [15:0] address;
  logic [7:0]  command;
  logic [5:0]  bit_count;
} frame_req_t;

// One mark/space pair as it crosses the output handshake.
typedef struct packed {
  logic [15:0] mark_us;
  logic [15:0] space_us;
  logic [1:0]  status;
  logic        last;
} pulse_pair_t;

class pulse_pair_scoreboard;
  pulse_pair_t expected_pairs[$];
  int unsigned failures = 0;

  function void flag_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  function void push_pair(logic [15:0] mark, logic [15:0] space, logic [1:0] code,
                          logic is_last);
    pulse_pair_t p;
    p.mark_us  = mark;
    p.space_us = space;
    p.status   = code;
    p.last     = is_last;
    expected_pairs.push_back(p);
  endfunction

  // Work out every pair that one accepted request must produce.
  function void add_frame_request(frame_req_t r);
    logic [31:0] word;
    int          nbits;
    int          span_us;
    int          gap_us;
    if (r.opcode == OP_UNSUP) begin
      push_pair(16'd0, 16'd0, STATUS_BAD_PROTO, 1'b1);
      return;
    end
    nbits = r.bit_count;
    if (r.opcode <= OP_SAMSUNG) begin
      // NEC family: assembled frames are always 32 bits.
      if (r.from_address_command) begin
        nbits = 32;
        case (r.opcode)
          OP_NEC:    word[31:16] = {r.address[7:0], ~r.address[7:0]};
          OP_NECEXT: word[31:16] = r.address;
          default:   word[31:16] = {r.address[7:0], r.address[7:0]};
        endcase
        word[15:0] = {r.command, ~r.command};
      end else begin
        word = r.data_word;
      end
    end else begin
      // SIRC family: fixed lengths, except raw SONY which takes the bit count.
      word = r.from_address_command ? {12'd0, r.address[12:0], r.command[6:0]} : r.data_word;
      case (r.opcode)
        OP_SIRC12: nbits = SIRC12_BITS;
        OP_SIRC15: nbits = SIRC15_BITS;
        OP_SIRC20: nbits = SIRC20_BITS;
        default:   if (r.from_address_command) nbits = SIRC12_BITS;
      endcase
    end
    if (nbits == 0 || nbits > MAX_FRAME_BITS) begin
      push_pair(16'd0, 16'd0, STATUS_BAD_COUNT, 1'b1);
      return;
    end
    if (r.opcode <= OP_SAMSUNG) begin
      // Samsung uses a 4500 us leader mark, equal to the NEC leader space.
      push_pair(r.opcode == OP_SAMSUNG ? T_NEC_LEAD_SPACE : T_NEC_LEAD_MARK,
                T_NEC_LEAD_SPACE, STATUS_OK, 1'b0);
      for (int i = nbits - 1; i >= 0; i--)
        push_pair(T_NEC_BIT_MARK, word[i] ? T_NEC_ONE_SPACE : T_NEC_BIT_MARK,
                  STATUS_OK, 1'b0);
      push_pair(T_NEC_BIT_MARK, T_NEC_STOP_SPACE, STATUS_OK, 1'b1);
    end else begin
      // The last space pads the frame to 45 ms, or adds one unit if already longer.
      span_us = T_SIRC_LEAD_TOTAL;
      for (int i = 0; i < nbits; i++)
        span_us += word[i] ? int'(T_SIRC_ONE_BIT) : 2 * int'(T_SIRC_UNIT);
      gap_us = (span_us < int'(T_SIRC_FRAME)) ? int'(T_SIRC_FRAME) - span_us
                                              : int'(T_SIRC_UNIT);
      push_pair(T_SIRC_LEAD_MARK, T_SIRC_UNIT, STATUS_OK, 1'b0);
      for (int i = 0; i < nbits; i++)
        push_pair(word[i] ? T_SIRC_ONE_MARK : T_SIRC_UNIT,
                  (i == nbits - 1) ? 16'(int'(T_SIRC_UNIT) + gap_us) : T_SIRC_UNIT,
                  STATUS_OK, i == nbits - 1);
    end
  endfunction

  // Compare one accepted pair with the oldest pair still expected.
  function void check_pair(pulse_pair_t got);
    pulse_pair_t want;
    if (expected_pairs.size() == 0) begin
      flag_failure($sformatf("unexpected pair mark %0d space %0d status %0d last %0d",
                             got.mark_us, got.space_us, got.status, got.last));
      return;
    end
    want = expected_pairs.pop_front();
    if (got.mark_us !== want.mark_us)
      flag_failure($sformatf("mark_us expected %0d, got %0d", want.mark_us, got.mark_us));
    if (got.space_us !== want.space_us)
      flag_failure($sformatf("space_us expected %0d, got %0d", want.space_us, got.space_us));
    if (got.status !== want.status)
      flag_failure($sformatf("status expected %0d, got %0d", want.status, got.status));
    if (got.last !== want.last)
      flag_failure($sformatf("last expected %0d, got %0d", want.last, got.last));
  endfunction
endclass

module ir_pulse_frame_encoder_tb;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic        from_address_command = 1'b0;
  logic [31:0] data_word = '0;
  logic [15:0] address = '0;
  logic [7:0]  command = '0;
  logic [5:0]  bit_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] mark_us;
  logic [15:0] space_us;
  logic [1:0]  status;
  logic        last;

  logic        steady_phase = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  pulse_pair_scoreboard frame_pairs = new;

  ir_pulse_frame_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .from_address_command(from_address_command),
    .data_word(data_word), .address(address), .command(command),
    .bit_count(bit_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .mark_us(mark_us), .space_us(space_us), .status(status), .last(last)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly short, a few long.
  function automatic int idle_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stalls, suppressed during steady stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady_phase && $urandom_range(0, 99) < 20) begin
      out_ready  <= 1'b0;
      stall_left <= idle_length() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watch both handshakes and check every pair that leaves the block.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      frame_pairs.add_frame_request({opcode, from_address_command, data_word, address,
                                     command, bit_count});
    if (!rst && out_valid && out_ready)
      frame_pairs.check_pair({mark_us, space_us, status, last});
  end

  // End the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request, after an optional gap, and hold it until accepted.
  task automatic send_request(frame_req_t r);
    int gap;
    gap = (steady_phase || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid             <= 1'b1;
    opcode               <= r.opcode;
    from_address_command <= r.from_address_command;
    data_word            <= r.data_word;
    address              <= r.address;
    command              <= r.command;
    bit_count            <= r.bit_count;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random request, weighted toward legal bit counts and known protocols.
  function automatic frame_req_t random_request();
    frame_req_t r;
    int         sel;
    r.opcode = ($urandom_range(0, 19) == 0) ? OP_UNSUP : 3'($urandom_range(0, 6));
    r.from_address_command = 1'($urandom_range(0, 1));
    r.data_word = $urandom;
    r.address   = 16'($urandom_range(0, 16'hffff));
    r.command   = 8'($urandom_range(0, 8'hff));
    sel = $urandom_range(0, 19);
    if (sel == 0)     r.bit_count = 6'd0;
    else if (sel < 3) r.bit_count = 6'($urandom_range(33, 63));
    else if (sel < 6) r.bit_count = 6'd32;
    else              r.bit_count = 6'($urandom_range(1, 32));
    return r;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Assembled frames of every protocol except SIRC20, several at the field extremes.
    send_request('{OP_NEC,     1'b1, 32'h0,        16'h0000, 8'h00, 6'd0});
    send_request('{OP_NEC,     1'b1, 32'h0,        16'hffff, 8'hff, 6'd63});
    send_request('{OP_NECEXT,  1'b1, 32'h0,        16'ha5c3, 8'h5a, 6'd5});
    send_request('{OP_SAMSUNG, 1'b1, 32'h0,        16'h0007, 8'he6, 6'd0});
    send_request('{OP_SIRC12,  1'b1, 32'h0,        16'hffff, 8'hff, 6'd0});
    send_request('{OP_SIRC15,  1'b1, 32'h0,        16'h1234, 8'h80, 6'd40});
    send_request('{OP_SONY,    1'b1, 32'h0,        16'h1fff, 8'h7f, 6'd0});
    // Raw NEC family frames, including shortest, longest and unused high bits.
    send_request('{OP_NEC,     1'b0, 32'hffffffff, 16'h0,    8'h0,  6'd32});
    send_request('{OP_NEC,     1'b0, 32'h00000000, 16'h0,    8'h0,  6'd1});
    send_request('{OP_NEC,     1'b0, 32'h80000001, 16'h0,    8'h0,  6'd31});
    send_request('{OP_NECEXT,  1'b0, 32'h12345678, 16'h0,    8'h0,  6'd0});
    send_request('{OP_SAMSUNG, 1'b0, 32'hdeadbeef, 16'h0,    8'h0,  6'd33});
    send_request('{OP_NEC,     1'b0, 32'hffffffff, 16'h0,    8'h0,  6'd63});
    // Raw SIRC frames ignore the bit count.
    send_request('{OP_SIRC20,  1'b0, 32'hffffffff, 16'h0,    8'h0,  6'd0});
    send_request('{OP_SIRC12,  1'b0, 32'h00000000, 16'h0,    8'h0,  6'd63});
    send_request('{OP_SIRC15,  1'b0, 32'haaaaaaaa, 16'h0,    8'h0,  6'd7});
    // Raw SONY: frames longer than 45 ms, one exactly at 45 ms, bad counts.
    send_request('{OP_SONY,    1'b0, 32'hffffffff, 16'h0,    8'h0,  6'd32});
    send_request('{OP_SONY,    1'b0, 32'h0000003f, 16'h0,    8'h0,  6'd32});
    send_request('{OP_SONY,    1'b0, 32'h00ffffff, 16'h0,    8'h0,  6'd24});
    send_request('{OP_SONY,    1'b0, 32'h55555555, 16'h0,    8'h0,  6'd0});
    send_request('{OP_SONY,    1'b0, 32'h55555555, 16'h0,    8'h0,  6'd33});
    // Unsupported protocol in both modes.
    send_request('{OP_UNSUP,   1'b1, 32'h0,        16'hffff, 8'hff, 6'd12});
    send_request('{OP_UNSUP,   1'b0, 32'hffffffff, 16'h0,    8'h0,  6'd0});

    // Random requests, with occasional stretches free of idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) steady_phase <= ($urandom_range(0, 3) == 0);
      send_request(random_request());
    end
    in_valid <= 1'b0;

    while (frame_pairs.expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_pairs.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
